// ----- rtl/cfrack_pkg.sv -----
// shared types and constants of the checksummed frame receiver
package cfrack_pkg;

	// input opcodes
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_ACK    = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_ACK_FLAG = 2'd0;
	localparam logic [1:0] REG_ACK_SRC  = 2'd1;
	localparam logic [1:0] REG_ACK_DST  = 2'd2;
	localparam logic [1:0] REG_END_CMD  = 2'd3;

	// configuration reset values
	localparam logic [7:0] RST_ACK_FLAG = 8'h7E;
	localparam logic [7:0] RST_ACK_SRC  = 8'hFF;
	localparam logic [7:0] RST_ACK_DST  = 8'hFF;
	localparam logic [7:0] RST_END_CMD  = 8'h02;

	// command queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	// configuration registers
	typedef struct packed {
		logic [7:0] ack_flag;
		logic [7:0] ack_src;
		logic [7:0] ack_dst;
		logic [7:0] end_cmd;
	} cfg_t;

	// one queued command: a frame status (with its acknowledge) or a read
	typedef struct packed {
		logic        is_read;
		logic        accepted;
		logic [7:0]  data;
		logic [7:0]  cmd;
		logic [7:0]  seq;
		logic        done;
		logic [17:0] committed;
	} cmd_t;

endpackage

// ----- rtl/cfrack_ram.sv -----
// generic single-port-write ram with registered read
module cfrack_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/cfrack_front.sv -----
// front end: frame parser, file store writes and reads, command issue
module cfrack_front #(
	parameter int FILE_DEPTH   = 131072,
	parameter int MAX_DATA_LEN = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              opcode,
	input  logic [7:0]        data_byte,
	input  logic              frame_start,
	input  logic [16:0]       read_address,
	input  logic [7:0]        end_cmd,
	output logic              s1_valid,
	output cfrack_pkg::cmd_t  s1_item
);

	localparam int AW = $clog2(FILE_DEPTH);
	localparam int CW = $clog2(FILE_DEPTH + 1);
	localparam int SW = ((CW > 16) ? CW : 16) + 1;
	localparam int LW = ((CW > 17) ? CW : 17) + 1;

	localparam logic [2:0] POS_CMD    = 3'd3;
	localparam logic [2:0] POS_SEQ    = 3'd4;
	localparam logic [2:0] POS_LEN_HI = 3'd5;
	localparam logic [2:0] POS_LEN_LO = 3'd6;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_HDR  = 5'b00010,
		S_DATA = 5'b00100,
		S_SUMH = 5'b01000,
		S_SUML = 5'b10000
	} state_t;

	state_t          state_q, state_d, cur_st;
	logic [2:0]      hdr_cnt_q, hdr_cnt_d, cur_pos;
	logic [15:0]     len_q, len_d, rem_q, rem_d, full_len;
	logic [15:0]     sum_q, sum_d, cur_sum;
	logic [7:0]      sumh_q, sumh_d;
	logic [7:0]      cmd_q, cmd_d, seq_q, seq_d, exp_seq_q, exp_seq_d;
	logic [CW-1:0]   committed_q, committed_d, wr_ptr_q, wr_ptr_d;
	logic            done_q, done_d;
	logic            fin, fin_acc, we, too_big, overflow, sum_ok, seq_ok;
	logic            is_read, rd_ok, rd_ok_s1;
	logic [7:0]      rdata;
	cfrack_pkg::cmd_t item_s1;

	assign is_read  = in_valid && (opcode == cfrack_pkg::OP_READ);
	assign cur_st   = frame_start ? S_HDR : state_q;
	assign cur_pos  = frame_start ? 3'd0 : hdr_cnt_q;
	assign cur_sum  = frame_start ? 16'd0 : sum_q;
	assign full_len = {len_q[15:8], data_byte};
	assign too_big  = {1'b0, full_len} > 17'(MAX_DATA_LEN);
	assign overflow = (SW'(committed_q) + SW'(full_len)) > SW'(FILE_DEPTH);
	assign sum_ok   = (sumh_q == sum_q[15:8]) && (data_byte == sum_q[7:0]);
	assign seq_ok   = (seq_q == exp_seq_q) || (seq_q == 8'(exp_seq_q + 8'd1));
	assign rd_ok    = (LW'(read_address) < LW'(committed_q)) &&
	                  (LW'(read_address) < LW'(FILE_DEPTH));

	always_comb begin
		state_d     = state_q;
		hdr_cnt_d   = hdr_cnt_q;
		len_d       = len_q;
		rem_d       = rem_q;
		sum_d       = sum_q;
		sumh_d      = sumh_q;
		cmd_d       = cmd_q;
		seq_d       = seq_q;
		exp_seq_d   = exp_seq_q;
		committed_d = committed_q;
		wr_ptr_d    = wr_ptr_q;
		done_d      = done_q;
		we          = 1'b0;
		fin         = 1'b0;
		fin_acc     = 1'b0;
		if (in_valid && (opcode == cfrack_pkg::OP_FRAME)) begin
			unique case (cur_st)
				S_IDLE: begin
					state_d = S_IDLE;
				end
				S_HDR: begin
					state_d   = S_HDR;
					sum_d     = cur_sum + {8'h00, data_byte};
					hdr_cnt_d = cur_pos + 3'd1;
					case (cur_pos)
						POS_CMD:    cmd_d = data_byte;
						POS_SEQ:    seq_d = data_byte;
						POS_LEN_HI: len_d = {data_byte, 8'h00};
						POS_LEN_LO: begin
							len_d = full_len;
							if (too_big || overflow) begin
								fin     = 1'b1;
								state_d = S_IDLE;
							end else begin
								wr_ptr_d = committed_q;
								rem_d    = full_len;
								state_d  = (full_len == 16'd0) ? S_SUMH : S_DATA;
							end
						end
						default: ;
					endcase
				end
				S_DATA: begin
					sum_d    = sum_q + {8'h00, data_byte};
					we       = LW'(wr_ptr_q) < LW'(FILE_DEPTH);
					wr_ptr_d = wr_ptr_q + CW'(1);
					rem_d    = rem_q - 16'd1;
					if (rem_q == 16'd1) begin
						state_d = S_SUMH;
					end
				end
				S_SUMH: begin
					sumh_d  = data_byte;
					state_d = S_SUML;
				end
				S_SUML: begin
					fin     = 1'b1;
					fin_acc = sum_ok && seq_ok;
					state_d = S_IDLE;
				end
				default: state_d = S_IDLE;
			endcase
		end
		if (fin) begin
			if (fin_acc) begin
				committed_d = committed_q + CW'(len_q);
				exp_seq_d   = exp_seq_q + 8'd1;
			end
			if (cmd_q == end_cmd) begin
				done_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hdr_cnt_q   <= '0;
			len_q       <= '0;
			rem_q       <= '0;
			sum_q       <= '0;
			sumh_q      <= '0;
			cmd_q       <= '0;
			seq_q       <= '0;
			exp_seq_q   <= '0;
			committed_q <= '0;
			wr_ptr_q    <= '0;
			done_q      <= 1'b0;
			s1_valid    <= 1'b0;
		end else begin
			state_q     <= state_d;
			hdr_cnt_q   <= hdr_cnt_d;
			len_q       <= len_d;
			rem_q       <= rem_d;
			sum_q       <= sum_d;
			sumh_q      <= sumh_d;
			cmd_q       <= cmd_d;
			seq_q       <= seq_d;
			exp_seq_q   <= exp_seq_d;
			committed_q <= committed_d;
			wr_ptr_q    <= wr_ptr_d;
			done_q      <= done_d;
			s1_valid    <= is_read || fin;
		end
	end

	// command snapshot, registered together with the store's read byte
	always_ff @(posedge clk) begin
		if (in_valid) begin
			item_s1.is_read   <= is_read;
			item_s1.accepted  <= fin_acc;
			item_s1.data      <= 8'h00;
			item_s1.cmd       <= cmd_q;
			item_s1.seq       <= seq_q;
			item_s1.done      <= done_d;
			item_s1.committed <= 18'(committed_d);
			rd_ok_s1          <= rd_ok;
		end
	end

	always_comb begin
		s1_item      = item_s1;
		s1_item.data = (item_s1.is_read && rd_ok_s1) ? rdata : 8'h00;
	end

	cfrack_ram #(
		.W     (8),
		.DEPTH (FILE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (wr_ptr_q[AW-1:0]),
		.wdata (data_byte),
		.re    (is_read),
		.raddr (AW'(read_address)),
		.rdata (rdata)
	);

endmodule

// ----- rtl/cfrack_queue.sv -----
// short command queue between front and back
module cfrack_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  cfrack_pkg::cmd_t            push_item,
	input  logic                        pop,
	output cfrack_pkg::cmd_t            head,
	output logic                        q_empty,
	output logic [cfrack_pkg::Q_CW-1:0] count
);

	cfrack_pkg::cmd_t              mem_q [cfrack_pkg::Q_DEPTH];
	logic [cfrack_pkg::Q_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [cfrack_pkg::Q_CW-1:0]   count_q;
	logic                          do_pop;

	assign do_pop  = pop && (count_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign q_empty = (count_q == '0);
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + cfrack_pkg::Q_CW'(push) - cfrack_pkg::Q_CW'(do_pop);
		end
	end

endmodule

// ----- rtl/cfrack_back.sv -----
// back end: expands queued commands into result items behind an output register
module cfrack_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cfrack_pkg::cfg_t  cfg,
	input  cfrack_pkg::cmd_t  head,
	input  logic              q_empty,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output logic [1:0]        result_kind,
	output logic [7:0]        data_out,
	output logic              last_of_run,
	output logic              frame_accepted,
	output logic              transfer_done,
	output logic [17:0]       stored_length
);

	localparam logic [3:0] STEP_STATUS = 4'd0;
	localparam logic [3:0] STEP_FLAG   = 4'd1;
	localparam logic [3:0] STEP_SRC    = 4'd2;
	localparam logic [3:0] STEP_DST    = 4'd3;
	localparam logic [3:0] STEP_CMD    = 4'd4;
	localparam logic [3:0] STEP_SEQ    = 4'd5;
	localparam logic [3:0] STEP_LEN_HI = 4'd6;
	localparam logic [3:0] STEP_LEN_LO = 4'd7;
	localparam logic [3:0] STEP_SUM_HI = 4'd8;
	localparam logic [3:0] STEP_SUM_LO = 4'd9;

	logic [3:0]  step_q;
	logic        out_valid_q, advance, last;
	logic [15:0] ack_sum;
	logic [1:0]  kind;
	logic [7:0]  data;

	assign ack_sum = {8'h00, cfg.ack_flag} + {8'h00, cfg.ack_src} + {8'h00, cfg.ack_dst} +
	                 {8'h00, head.cmd} + {8'h00, head.seq};
	assign advance = !q_empty && (!out_valid_q || pop);
	assign last    = head.is_read || !head.accepted || (step_q == STEP_SUM_LO);
	assign q_pop   = advance && last;
	assign empty   = !out_valid_q;

	always_comb begin
		kind = cfrack_pkg::KIND_ACK;
		data = 8'h00;
		if (head.is_read) begin
			kind = cfrack_pkg::KIND_READ;
			data = head.data;
		end else begin
			case (step_q)
				STEP_STATUS: kind = cfrack_pkg::KIND_STATUS;
				STEP_FLAG:   data = cfg.ack_flag;
				STEP_SRC:    data = cfg.ack_src;
				STEP_DST:    data = cfg.ack_dst;
				STEP_CMD:    data = head.cmd;
				STEP_SEQ:    data = head.seq;
				STEP_LEN_HI: data = 8'h00;
				STEP_LEN_LO: data = 8'h00;
				STEP_SUM_HI: data = ack_sum[15:8];
				STEP_SUM_LO: data = ack_sum[7:0];
				default:     data = 8'h00;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_STATUS;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q      <= last ? STEP_STATUS : step_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_kind    <= kind;
			data_out       <= data;
			last_of_run    <= last;
			frame_accepted <= !head.is_read && head.accepted && (step_q == STEP_STATUS);
			transfer_done  <= head.done;
			stored_length  <= head.committed;
		end
	end

endmodule

// ----- rtl/checksummed_frame_receiver_ack_top.sv -----
// top level of the checksummed frame receiver with acknowledge
//
//  channel   direction  handshake          payload
//  input     in         push / full        opcode, data_byte, frame_start, read_address
//  results   out        empty / pop        result_kind, data_out, last_of_run,
//                                          frame_accepted, transfer_done, stored_length
//  config    in         cfg_we             cfg_index, cfg_data
//
// one input item per cycle while full is low; the first result of an item passes through
// the front stage, then the queue, then the output register before it reaches the ports.
// an accepted frame turns its last byte into ten result items, one per cycle while
// results are popped, out of a four-entry command queue; input stalls (full) once
// that queue, counting the item in the front's stage, has no room left.
// a read is one pass through the file store ram with its registered read port.
// reset clears control state at once, with no clearing pass over the file store.
module checksummed_frame_receiver_ack_top #(
	parameter int FILE_DEPTH   = 131072,
	parameter int MAX_DATA_LEN = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        opcode,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	input  logic [16:0] read_address,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  result_kind,
	output logic [7:0]  data_out,
	output logic        last_of_run,
	output logic        frame_accepted,
	output logic        transfer_done,
	output logic [17:0] stored_length,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfrack_pkg::cfg_t            cfg_q;
	cfrack_pkg::cmd_t            s1_item, head;
	logic                        s1_valid, q_empty, q_pop, in_valid;
	logic [cfrack_pkg::Q_CW-1:0] q_count;

	// room is kept for the item already in the front's s1 stage
	assign full     = ({1'b0, q_count} + (cfrack_pkg::Q_CW + 1)'(s1_valid)) >=
	                  (cfrack_pkg::Q_CW + 1)'(cfrack_pkg::Q_DEPTH);
	assign in_valid = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_flag <= cfrack_pkg::RST_ACK_FLAG;
			cfg_q.ack_src  <= cfrack_pkg::RST_ACK_SRC;
			cfg_q.ack_dst  <= cfrack_pkg::RST_ACK_DST;
			cfg_q.end_cmd  <= cfrack_pkg::RST_END_CMD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cfrack_pkg::REG_ACK_FLAG: cfg_q.ack_flag <= cfg_data;
				cfrack_pkg::REG_ACK_SRC:  cfg_q.ack_src  <= cfg_data;
				cfrack_pkg::REG_ACK_DST:  cfg_q.ack_dst  <= cfg_data;
				cfrack_pkg::REG_END_CMD:  cfg_q.end_cmd  <= cfg_data;
				default: ;
			endcase
		end
	end

	cfrack_front #(
		.FILE_DEPTH   (FILE_DEPTH),
		.MAX_DATA_LEN (MAX_DATA_LEN)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.opcode       (opcode),
		.data_byte    (data_byte),
		.frame_start  (frame_start),
		.read_address (read_address),
		.end_cmd      (cfg_q.end_cmd),
		.s1_valid     (s1_valid),
		.s1_item      (s1_item)
	);

	cfrack_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_valid),
		.push_item (s1_item),
		.pop       (q_pop),
		.head      (head),
		.q_empty   (q_empty),
		.count     (q_count)
	);

	cfrack_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.head           (head),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.pop            (pop),
		.empty          (empty),
		.result_kind    (result_kind),
		.data_out       (data_out),
		.last_of_run    (last_of_run),
		.frame_accepted (frame_accepted),
		.transfer_done  (transfer_done),
		.stored_length  (stored_length)
	);

endmodule

// ----- rtl/cfrack_checker.sv -----
// port-level checks of the frame receiver, bound to the top level
module cfrack_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  result_kind,
	input  logic        last_of_run,
	input  logic        frame_accepted,
	input  logic        transfer_done,
	input  logic [17:0] stored_length
);

	// a read and a rejected status each end their run
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && ((result_kind == cfrack_pkg::KIND_READ) ||
		((result_kind == cfrack_pkg::KIND_STATUS) && !frame_accepted)) |-> last_of_run)
		else $error("read or rejected status item not marked last");

	// acceptance is only flagged in a status item
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result_kind != cfrack_pkg::KIND_STATUS) |-> !frame_accepted)
		else $error("frame_accepted set outside a status item");

	// the acknowledge follows an accepted status without a gap
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && (result_kind == cfrack_pkg::KIND_STATUS) && frame_accepted |=>
		!empty && (result_kind == cfrack_pkg::KIND_ACK))
		else $error("acknowledge item missing after accepted status");

	// done and committed length never go back between items
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop ##1 !empty |->
		!($past(transfer_done) && !transfer_done) && (stored_length >= $past(stored_length)))
		else $error("transfer_done or stored_length went backward");

endmodule

bind checksummed_frame_receiver_ack_top cfrack_checker u_chk (.*);

// ----- verif/checksummed_frame_receiver_ack_check.sv -----
// checker: predicts frame status, acknowledge and store read results and compares them
module checksummed_frame_receiver_ack_check #(
	parameter int FILE_DEPTH   = 131072,
	parameter int MAX_DATA_LEN = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        opcode,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	input  logic [16:0] read_address,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  result_kind,
	input  logic [7:0]  data_out,
	input  logic        last_of_run,
	input  logic        frame_accepted,
	input  logic        transfer_done,
	input  logic [17:0] stored_length,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic        last;
		logic        accepted;
		logic        done;
		logic [17:0] length;
	} result_t;

	result_t          due_results[$];
	result_t          want;
	cfrack_pkg::cfg_t regs;

	// parser and store copy
	int         pos;
	logic       in_frame;
	logic [7:0] cmd_seen;
	logic [7:0] seq_seen;
	logic [15:0] frame_len;
	logic [15:0] sum;
	logic [7:0] sum_high;
	logic [7:0] next_seq;
	int         committed;
	logic       done;
	logic [7:0] store_mem [0:FILE_DEPTH-1];

	function automatic void queue_result(logic [1:0] kind, logic [7:0] data, logic acc,
			logic last);
		result_t r;
		r.kind = kind;
		r.data = data;
		r.last = last;
		r.accepted = acc;
		r.done = done;
		r.length = 18'(committed);
		due_results.push_back(r);
	endfunction

	function automatic void close_frame(logic ok);
		logic [15:0] ack_sum;
		in_frame = 1'b0;
		if (ok) begin
			committed = committed + frame_len;
			next_seq = next_seq + 8'd1;
		end
		if (cmd_seen == regs.end_cmd) begin
			done = 1'b1;
		end
		queue_result(cfrack_pkg::KIND_STATUS, 8'h00, ok, !ok);
		if (ok) begin
			ack_sum = {8'h00, regs.ack_flag} + {8'h00, regs.ack_src} + {8'h00, regs.ack_dst}
				+ {8'h00, cmd_seen} + {8'h00, seq_seen};
			queue_result(cfrack_pkg::KIND_ACK, regs.ack_flag, 1'b0, 1'b0);
			queue_result(cfrack_pkg::KIND_ACK, regs.ack_src, 1'b0, 1'b0);
			queue_result(cfrack_pkg::KIND_ACK, regs.ack_dst, 1'b0, 1'b0);
			queue_result(cfrack_pkg::KIND_ACK, cmd_seen, 1'b0, 1'b0);
			queue_result(cfrack_pkg::KIND_ACK, seq_seen, 1'b0, 1'b0);
			queue_result(cfrack_pkg::KIND_ACK, 8'h00, 1'b0, 1'b0);
			queue_result(cfrack_pkg::KIND_ACK, 8'h00, 1'b0, 1'b0);
			queue_result(cfrack_pkg::KIND_ACK, ack_sum[15:8], 1'b0, 1'b0);
			queue_result(cfrack_pkg::KIND_ACK, ack_sum[7:0], 1'b0, 1'b1);
		end
	endfunction

	function automatic void take_item(logic op, logic [7:0] b, logic fs, logic [16:0] addr);
		logic [7:0] v;
		logic seq_ok;
		if (op == cfrack_pkg::OP_READ) begin
			v = 8'h00;
			if (addr < committed) begin
				v = store_mem[addr];
			end
			queue_result(cfrack_pkg::KIND_READ, v, 1'b0, 1'b1);
			return;
		end
		if (fs) begin
			in_frame = 1'b1;
			pos = 0;
			sum = 16'h0000;
		end
		if (!in_frame) begin
			return;
		end
		if (pos < 7) begin
			sum = sum + b;
			case (pos)
				3: cmd_seen = b;
				4: seq_seen = b;
				5: frame_len = {b, 8'h00};
				6: frame_len = {frame_len[15:8], b};
				default: ;
			endcase
			pos++;
			// header checks fire right after the length
			if (pos == 7 && (frame_len > MAX_DATA_LEN || committed + frame_len > FILE_DEPTH)) begin
				close_frame(1'b0);
			end
		end else if (pos < 7 + frame_len) begin
			// data lands past the committed end before the checksum is known
			store_mem[committed + pos - 7] = b;
			sum = sum + b;
			pos++;
		end else if (pos == 7 + frame_len) begin
			sum_high = b;
			pos++;
		end else begin
			pos++;
			seq_ok = (seq_seen == next_seq) || (seq_seen == next_seq + 8'd1);
			close_frame(sum_high == sum[15:8] && b == sum[7:0] && seq_ok);
		end
	endfunction

	function automatic void check_field(string name, logic [17:0] expd, logic [17:0] got);
		if (got !== expd) begin
			$error("%s: expected %0d, got %0d", name, expd, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.ack_flag = cfrack_pkg::RST_ACK_FLAG;
			regs.ack_src = cfrack_pkg::RST_ACK_SRC;
			regs.ack_dst = cfrack_pkg::RST_ACK_DST;
			regs.end_cmd = cfrack_pkg::RST_END_CMD;
			pos = 0;
			in_frame = 1'b0;
			cmd_seen = 8'h00;
			seq_seen = 8'h00;
			frame_len = 16'h0000;
			sum = 16'h0000;
			sum_high = 8'h00;
			next_seq = 8'h00;
			committed = 0;
			done = 1'b0;
			due_results.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cfrack_pkg::REG_ACK_FLAG: regs.ack_flag = cfg_data;
					cfrack_pkg::REG_ACK_SRC:  regs.ack_src = cfg_data;
					cfrack_pkg::REG_ACK_DST:  regs.ack_dst = cfg_data;
					cfrack_pkg::REG_END_CMD:  regs.end_cmd = cfg_data;
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					$error("result item popped with none expected");
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("result_kind", want.kind, result_kind);
					check_field("data_out", want.data, data_out);
					check_field("last_of_run", want.last, last_of_run);
					check_field("frame_accepted", want.accepted, frame_accepted);
					check_field("transfer_done", want.done, transfer_done);
					check_field("stored_length", want.length, stored_length);
				end
			end
			if (push && !full) begin
				take_item(opcode, data_byte, frame_start, read_address);
			end
			outstanding = due_results.size();
		end
	end

endmodule

// ----- verif/checksummed_frame_receiver_ack_top_test.sv -----
// testbench top: frame, read and register traffic for the checksummed frame receiver
module checksummed_frame_receiver_ack_top_test;

	localparam int FILE_DEPTH   = 131072;
	localparam int MAX_DATA_LEN = 1024;
	localparam int RUN_LIMIT    = 8000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        opcode = cfrack_pkg::OP_FRAME;
	logic [7:0]  data_byte = 8'h00;
	logic        frame_start = 1'b0;
	logic [16:0] read_address = 17'h00000;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  data_out;
	logic        last_of_run;
	logic        frame_accepted;
	logic        transfer_done;
	logic [17:0] stored_length;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = cfrack_pkg::REG_ACK_FLAG;
	logic [7:0]  cfg_data = 8'h00;

	int          mismatches;
	int          outstanding;
	int          gap_pct = 0;
	int          stall_pct = 0;
	int          sent = 0;
	logic [7:0]  seq_guess = 8'h00;
	int          committed_guess = 0;
	logic        frame_open = 1'b0;
	logic [7:0]  end_cmd_now = cfrack_pkg::RST_END_CMD;

	checksummed_frame_receiver_ack_top #(
		.FILE_DEPTH(FILE_DEPTH),
		.MAX_DATA_LEN(MAX_DATA_LEN)
	) u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.data_byte(data_byte), .frame_start(frame_start), .read_address(read_address),
		.empty(empty), .pop(pop), .result_kind(result_kind), .data_out(data_out),
		.last_of_run(last_of_run), .frame_accepted(frame_accepted),
		.transfer_done(transfer_done), .stored_length(stored_length),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	checksummed_frame_receiver_ack_check #(
		.FILE_DEPTH(FILE_DEPTH),
		.MAX_DATA_LEN(MAX_DATA_LEN)
	) u_check (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.data_byte(data_byte), .frame_start(frame_start), .read_address(read_address),
		.empty(empty), .pop(pop), .result_kind(result_kind), .data_out(data_out),
		.last_of_run(last_of_run), .frame_accepted(frame_accepted),
		.transfer_done(transfer_done), .stored_length(stored_length),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#(RUN_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic push_item(input logic op, input logic [7:0] b, input logic fs,
			input logic [16:0] addr);
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		data_byte <= b;
		frame_start <= fs;
		read_address <= addr;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_read(input logic [16:0] addr);
		push_item(cfrack_pkg::OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), addr);
		sent++;
	endtask

	function automatic logic [16:0] pick_address();
		if (committed_guess > 0 && $urandom_range(1) == 1) begin
			return 17'($urandom_range(committed_guess - 1));
		end
		return 17'($urandom_range(FILE_DEPTH - 1));
	endfunction

	// cut < 0 sends the whole frame, otherwise only the first cut bytes
	task automatic send_frame(input logic [7:0] cmd, input logic [7:0] seq, input int len,
			input logic bad_sum, input int cut, input int read_pct);
		logic [7:0]  fb[$];
		logic [15:0] fsum;
		logic        header_only;
		logic        good;
		int          i;
		header_only = (len > MAX_DATA_LEN) || (committed_guess + len > FILE_DEPTH);
		fb.push_back(8'($urandom_range(255)));
		fb.push_back(8'($urandom_range(255)));
		fb.push_back(8'($urandom_range(255)));
		fb.push_back(cmd);
		fb.push_back(seq);
		fb.push_back(len[15:8]);
		fb.push_back(len[7:0]);
		if (!header_only) begin
			for (i = 0; i < len; i++) begin
				fb.push_back(8'($urandom_range(255)));
			end
			fsum = 16'h0000;
			for (i = 0; i < fb.size(); i++) begin
				fsum = fsum + fb[i];
			end
			if (bad_sum) begin
				fsum = fsum ^ (16'h0001 << $urandom_range(15));
			end
			fb.push_back(fsum[15:8]);
			fb.push_back(fsum[7:0]);
		end
		if (cut < 0 || cut > fb.size()) begin
			cut = fb.size();
		end
		for (i = 0; i < cut; i++) begin
			if (i > 0 && $urandom_range(99) < read_pct) begin
				send_read(pick_address());
			end
			push_item(cfrack_pkg::OP_FRAME, fb[i], i == 0, 17'($urandom_range(FILE_DEPTH - 1)));
			sent++;
		end
		frame_open = (cut < fb.size());
		good = !frame_open && !header_only && !bad_sum
			&& (seq == seq_guess || seq == seq_guess + 8'd1);
		if (good) begin
			seq_guess = seq_guess + 8'd1;
			committed_guess += len;
		end
	endtask

	task automatic set_registers(input logic [7:0] flag, input logic [7:0] src,
			input logic [7:0] dst, input logic [7:0] endc);
		cfg_we <= 1'b1;
		cfg_index <= cfrack_pkg::REG_ACK_FLAG;
		cfg_data <= flag;
		@(negedge clk);
		cfg_index <= cfrack_pkg::REG_ACK_SRC;
		cfg_data <= src;
		@(negedge clk);
		cfg_index <= cfrack_pkg::REG_ACK_DST;
		cfg_data <= dst;
		@(negedge clk);
		cfg_index <= cfrack_pkg::REG_END_CMD;
		cfg_data <= endc;
		@(negedge clk);
		cfg_we <= 1'b0;
		end_cmd_now = endc;
	endtask

	// hold input until every expected result is out, then let the pipeline run dry
	task automatic settle();
		push <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic random_traffic(input int quota);
		int         start;
		int         r;
		int         len;
		int         cut;
		logic [7:0] cmd;
		logic [7:0] seq;
		start = sent;
		while (sent - start < quota) begin
			r = $urandom_range(99);
			if (r < 65) begin
				r = $urandom_range(99);
				if (r < 5) begin
					len = $urandom_range(65535, MAX_DATA_LEN + 1);
				end else if (r < 15) begin
					len = $urandom_range(64, 9);
				end else begin
					len = $urandom_range(8);
				end
				cmd = ($urandom_range(3) == 0) ? end_cmd_now : 8'($urandom_range(255));
				r = $urandom_range(99);
				if (r < 40) begin
					seq = seq_guess;
				end else if (r < 85) begin
					seq = seq_guess + 8'd1;
				end else begin
					seq = seq_guess + 8'd2 + 8'($urandom_range(253));
				end
				cut = ($urandom_range(9) == 0) ? 1 + $urandom_range(len + 7) : -1;
				send_frame(cmd, seq, len, $urandom_range(99) < 15, cut, 8);
			end else if (r < 85 || frame_open) begin
				send_read(pick_address());
			end else begin
				// stray bytes between frames are dropped by the block
				repeat ($urandom_range(3, 1)) begin
					push_item(cfrack_pkg::OP_FRAME, 8'($urandom_range(255)), 1'b0,
						17'($urandom_range(FILE_DEPTH - 1)));
				end
			end
		end
	endtask

	initial begin
		int ph;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part with the reset register values
		push_item(cfrack_pkg::OP_FRAME, 8'h00, 1'b0, 17'h00000);
		push_item(cfrack_pkg::OP_FRAME, 8'hFF, 1'b0, 17'h1FFFF);
		send_read(17'h00000);
		send_read(17'h1FFFF);
		send_frame(cfrack_pkg::RST_END_CMD, 8'h00, 1, 1'b0, -1, 15);
		send_read(17'h00000);
		send_frame(8'hFF, seq_guess, 16'hFFFF, 1'b0, -1, 0);
		send_frame(8'h00, seq_guess + 8'd1, 0, 1'b0, -1, 0);
		send_frame(8'h5A, seq_guess, 4, 1'b0, 2, 0);

		for (ph = 0; ph < 4; ph++) begin
			settle();
			case (ph)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
					set_registers(8'h00, 8'h00, 8'h00, 8'h00);
				end
				1: begin
					gap_pct = 75;
					stall_pct = 0;
					set_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
				end
				2: begin
					gap_pct = 0;
					stall_pct = 75;
					set_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)));
				end
				default: begin
					gap_pct = 31;
					stall_pct = 31;
					set_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)));
				end
			endcase
			random_traffic(30);
		end

		// closing reads across the whole store
		settle();
		gap_pct = 0;
		stall_pct = 0;
		send_read(17'(FILE_DEPTH - 1));
		send_read(17'h00000);
		repeat (6) send_read(17'($urandom_range(FILE_DEPTH - 1)));
		settle();

		if (mismatches == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
